/* hdl/distinct_prime_sum_counter_core_defines.svh */
// Assertion macros for the distinct prime sum counter.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef DISTINCT_PRIME_SUM_COUNTER_CORE_DEFINES_SVH
`define DISTINCT_PRIME_SUM_COUNTER_CORE_DEFINES_SVH

// Clocked property, off while reset is held.
`define DPSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define DPSC_ASSERT_NEVER(lbl, cond, msg) \
    `DPSC_ASSERT(lbl, !(cond), msg)

`endif

/* hdl/dpsc_pkg.sv */
// Shared types, constants and the saturating add for the prime sum counter.
// No dependencies.
package dpsc_pkg;

    localparam int SUM_W       = 12;
    localparam int PARTS_W     = 5;
    localparam int COUNT_W     = 32;
    localparam int ENTRY_W     = COUNT_W + 1;
    localparam int FIRST_PRIME = 2;

    // bit COUNT_W is the sticky saturation flag, low bits the count
    typedef logic [ENTRY_W-1:0] t_entry;

    localparam t_entry SAT_ENTRY = '1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_bld_stat;

    function automatic t_entry sat_add(input t_entry a, input t_entry b);
        t_entry r;
        r = {1'b0, a[COUNT_W-1:0]} + {1'b0, b[COUNT_W-1:0]};
        if (a[COUNT_W] || b[COUNT_W] || r[COUNT_W]) begin
            r = SAT_ENTRY;
        end
        return r;
    endfunction

endpackage

/* hdl/distinct_prime_sum_counter_core.sv */
// Top level of the distinct prime sum counter: query handshake, output
// register and the ways table. Depends on dpsc_pkg, dpsc_table_ram, dpsc_builder.
//
// Answers how many sets of exactly i_part_count distinct primes sum to
// i_sum_target. The first query after reset starts the table build: a clear
// pass that also initializes the prime flags, a sieve that marks the multiples
// of each prime up to sqrt(MAX_SUM), starting at its square, and a knapsack
// pass for each prime p up to MAX_SUM. The build is limited by the one write
// port of the ways table, which takes one entry update a cycle. Once built,
// each query is one table read into the memory output register, which is
// copied into the output register once that is free. A new query is taken
// while a result still waits in the output register; out-of-range queries
// give ways zero and the out_of_range flag.
module distinct_prime_sum_counter_core #(
    parameter int MAX_SUM   = 2048,
    parameter int MAX_PARTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dpsc_pkg::SUM_W-1:0]    i_sum_target,
    input  logic [dpsc_pkg::PARTS_W-1:0]  i_part_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dpsc_pkg::COUNT_W-1:0]  o_ways,
    output logic                          o_saturated,
    output logic                          o_out_of_range
);
    import dpsc_pkg::*;

    localparam int ROW_LEN = MAX_PARTS + 1;
    localparam int DEPTH   = (MAX_SUM + 1) * ROW_LEN;
    localparam int AW      = $clog2(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_BUILD, S_LOOK, S_DATA} t_state;

    t_state                 r_state;
    logic                   r_table_valid;
    logic [SUM_W-1:0]       r_sum;
    logic [PARTS_W-1:0]     r_parts;
    logic                   r_oor;
    logic                   r_o_valid;
    logic [COUNT_W-1:0]     r_o_ways;
    logic                   r_o_sat;
    logic                   r_o_oor;

    t_bld_stat              bld_stat;
    logic                   bld_we;
    logic [AW-1:0]          bld_waddr;
    t_entry                 bld_wdata;
    logic                   bld_re;
    logic [AW-1:0]          bld_raddr0;
    logic [AW-1:0]          bld_raddr1;
    t_entry                 rdata0;
    t_entry                 rdata1;

    logic                   in_xfer;
    logic                   in_oor;
    logic                   q_re;
    logic [AW-1:0]          q_addr;
    logic                   out_free;

    assign in_xfer  = i_valid && (r_state == S_IDLE);
    assign in_oor   = (int'(i_sum_target) > MAX_SUM) || (int'(i_part_count) > MAX_PARTS);
    assign out_free = !r_o_valid || i_ready;

    // query read: straight from the ports once the table is built,
    // from the held query right after the build
    always_comb begin
        q_re   = 1'b0;
        q_addr = AW'(AW'(r_sum) * AW'(ROW_LEN) + AW'(r_parts));
        if (r_state == S_IDLE) begin
            q_re   = in_xfer && r_table_valid && !in_oor;
            q_addr = AW'(AW'(i_sum_target) * AW'(ROW_LEN) + AW'(i_part_count));
        end else if (r_state == S_LOOK) begin
            q_re = !r_oor;
        end
    end

    dpsc_builder #(
        .MAX_SUM   (MAX_SUM),
        .MAX_PARTS (MAX_PARTS),
        .AW        (AW)
    ) u_builder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_xfer && !r_table_valid),
        .o_stat   (bld_stat),
        .o_we     (bld_we),
        .o_waddr  (bld_waddr),
        .o_wdata  (bld_wdata),
        .o_re     (bld_re),
        .o_raddr0 (bld_raddr0),
        .o_raddr1 (bld_raddr1),
        .i_rdata0 (rdata0),
        .i_rdata1 (rdata1)
    );

    dpsc_table_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (bld_we),
        .i_waddr  (bld_waddr),
        .i_wdata  (bld_wdata),
        .i_re0    (bld_stat.busy ? bld_re : q_re),
        .i_raddr0 (bld_stat.busy ? bld_raddr0 : q_addr),
        .o_rdata0 (rdata0),
        .i_re1    (bld_re),
        .i_raddr1 (bld_raddr1),
        .o_rdata1 (rdata1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_table_valid <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            // S_DATA reloads the output register itself when it is free
            if (r_o_valid && i_ready && (r_state != S_DATA)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_sum   <= i_sum_target;
                        r_parts <= i_part_count;
                        r_oor   <= in_oor;
                        r_state <= r_table_valid ? S_DATA : S_BUILD;
                    end
                end
                S_BUILD: begin
                    if (bld_stat.done) begin
                        r_table_valid <= 1'b1;
                        r_state       <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    // read data stays in the memory output register until taken
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_ways  <= r_oor ? '0 : rdata0[COUNT_W-1:0];
                        r_o_sat   <= r_oor ? 1'b0 : rdata0[COUNT_W];
                        r_o_oor   <= r_oor;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_ways         = r_o_ways;
    assign o_saturated    = r_o_sat;
    assign o_out_of_range = r_o_oor;

endmodule

/* hdl/dpsc_flag_ram.sv */
// Prime flag memory: one write port, one read port with registered data.
// Uses no package items.
module dpsc_flag_ram #(
    parameter int DEPTH = 2049,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/dpsc_table_ram.sv */
// Ways table memory: one write port, two read ports with registered data.
// Depends on dpsc_pkg for the entry type.
module dpsc_table_ram #(
    parameter int DEPTH = 34833,
    parameter int AW    = 16
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dpsc_pkg::t_entry i_wdata,
    input  logic            i_re0,
    input  logic [AW-1:0]   i_raddr0,
    output dpsc_pkg::t_entry o_rdata0,
    input  logic            i_re1,
    input  logic [AW-1:0]   i_raddr1,
    output dpsc_pkg::t_entry o_rdata1
);
    import dpsc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata0;
    t_entry r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re0) begin
            r_rdata0 <= r_mem[i_raddr0];
        end
        if (i_re1) begin
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

/* hdl/dpsc_builder.sv */
// Table builder: clears the ways table, sieves primes into its flag memory,
// then runs the 0/1 knapsack update pass. Depends on dpsc_pkg, dpsc_flag_ram.
module dpsc_builder #(
    parameter int MAX_SUM   = 2048,
    parameter int MAX_PARTS = 16,
    parameter int AW        = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output dpsc_pkg::t_bld_stat o_stat,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output dpsc_pkg::t_entry   o_wdata,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr0,
    output logic [AW-1:0]     o_raddr1,
    input  dpsc_pkg::t_entry   i_rdata0,
    input  dpsc_pkg::t_entry   i_rdata1
);
    import dpsc_pkg::*;

    localparam int ROW_LEN = MAX_PARTS + 1;
    localparam int DEPTH   = (MAX_SUM + 1) * ROW_LEN;
    localparam int SW      = $clog2(MAX_SUM + 1);
    localparam int KW      = $clog2(MAX_PARTS + 1);
    localparam int MW      = $clog2(2 * MAX_SUM + 2);

    typedef enum logic [3:0] {
        B_IDLE, B_CLEAR, B_SV_CHK, B_SV_RD, B_SV_MARK,
        B_KP_CHK, B_KP_RD, B_KP_RUN, B_KP_DRAIN, B_DONE
    } t_bstate;

    t_bstate         r_state;
    logic [AW-1:0]   r_c;
    logic [SW-1:0]   r_p;
    logic [MW-1:0]   r_sq;
    logic [MW-1:0]   r_m;
    logic [KW-1:0]   r_k;
    logic [SW-1:0]   r_s;
    logic            r_pv;
    logic [AW-1:0]   r_wa;

    logic            flag_we;
    logic [SW-1:0]   flag_waddr;
    logic            flag_wdata;
    logic            flag_re;
    logic            flag_rdata;
    logic [AW-1:0]   addr0;
    logic [AW-1:0]   addr1;
    logic [MW-1:0]   n_m;
    logic [MW-1:0]   n_sq;
    logic            clear_flag;

    dpsc_flag_ram #(
        .DEPTH (MAX_SUM + 1),
        .AW    (SW)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_re    (flag_re),
        .i_raddr (r_p),
        .o_rdata (flag_rdata)
    );

    // entry (s, k) and its knapsack source (s - p, k - 1)
    assign addr0 = AW'(AW'(r_s) * AW'(ROW_LEN) + AW'(r_k));
    assign addr1 = AW'(AW'(r_s - r_p) * AW'(ROW_LEN) + AW'(r_k - KW'(1)));
    assign n_m   = MW'(r_m + MW'(r_p));
    assign n_sq  = MW'(r_sq + (MW'(r_p) << 1) + MW'(1));

    // flag memory is initialized alongside the table clear
    assign clear_flag = (r_state == B_CLEAR) && (int'(r_c) <= MAX_SUM);
    assign flag_we    = clear_flag || (r_state == B_SV_MARK);
    assign flag_waddr = clear_flag ? SW'(r_c) : SW'(r_m);
    assign flag_wdata = clear_flag ? (int'(r_c) >= FIRST_PRIME) : 1'b0;
    assign flag_re    = (r_state == B_SV_CHK) || (r_state == B_KP_CHK);

    // Writes land in the cycle after their reads. Within a prime all writes hit
    // row k while reads of later cells are row k at smaller sums or row k-1,
    // so no read overtakes a pending write.
    assign o_we     = (r_state == B_CLEAR) || r_pv;
    assign o_waddr  = (r_state == B_CLEAR) ? r_c : r_wa;
    assign o_wdata  = (r_state == B_CLEAR) ? ((r_c == '0) ? t_entry'(1) : '0)
                                           : sat_add(i_rdata0, i_rdata1);
    assign o_re     = (r_state == B_KP_RUN);
    assign o_raddr0 = addr0;
    assign o_raddr1 = addr1;

    assign o_stat.busy = (r_state != B_IDLE);
    assign o_stat.done = (r_state == B_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pv    <= 1'b0;
        end else begin
            r_pv <= (r_state == B_KP_RUN);
            unique case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_c     <= '0;
                        r_state <= B_CLEAR;
                    end
                end
                B_CLEAR: begin
                    r_c <= AW'(r_c + AW'(1));
                    if (r_c == AW'(DEPTH - 1)) begin
                        r_p     <= SW'(FIRST_PRIME);
                        r_sq    <= MW'(FIRST_PRIME * FIRST_PRIME);
                        r_state <= B_SV_CHK;
                    end
                end
                B_SV_CHK: begin
                    if (r_sq > MW'(MAX_SUM)) begin
                        r_p     <= SW'(FIRST_PRIME);
                        r_state <= B_KP_CHK;
                    end else begin
                        r_state <= B_SV_RD;
                    end
                end
                B_SV_RD: begin
                    if (flag_rdata) begin
                        r_m     <= r_sq;
                        r_state <= B_SV_MARK;
                    end else begin
                        r_p     <= SW'(r_p + SW'(1));
                        r_sq    <= n_sq;
                        r_state <= B_SV_CHK;
                    end
                end
                B_SV_MARK: begin
                    r_m <= n_m;
                    if (n_m > MW'(MAX_SUM)) begin
                        r_p     <= SW'(r_p + SW'(1));
                        r_sq    <= n_sq;
                        r_state <= B_SV_CHK;
                    end
                end
                B_KP_CHK: begin
                    r_state <= B_KP_RD;
                end
                B_KP_RD: begin
                    if (flag_rdata) begin
                        r_k     <= KW'(MAX_PARTS);
                        r_s     <= SW'(MAX_SUM);
                        r_state <= B_KP_RUN;
                    end else if (r_p == SW'(MAX_SUM)) begin
                        r_state <= B_DONE;
                    end else begin
                        r_p     <= SW'(r_p + SW'(1));
                        r_state <= B_KP_CHK;
                    end
                end
                B_KP_RUN: begin
                    r_wa <= addr0;
                    if (r_s == r_p) begin
                        if (r_k == KW'(1)) begin
                            r_state <= B_KP_DRAIN;
                        end else begin
                            r_k <= KW'(r_k - KW'(1));
                            r_s <= SW'(MAX_SUM);
                        end
                    end else begin
                        r_s <= SW'(r_s - SW'(1));
                    end
                end
                B_KP_DRAIN: begin
                    if (r_p == SW'(MAX_SUM)) begin
                        r_state <= B_DONE;
                    end else begin
                        r_p     <= SW'(r_p + SW'(1));
                        r_state <= B_KP_CHK;
                    end
                end
                B_DONE: begin
                    r_state <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/dpsc_checker.sv */
// Port-level assertions for distinct_prime_sum_counter_core and its bind.
// Depends on dpsc_pkg and distinct_prime_sum_counter_core_defines.svh.
`include "distinct_prime_sum_counter_core_defines.svh"

module dpsc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [dpsc_pkg::COUNT_W-1:0]  o_ways,
    input  logic                          o_saturated,
    input  logic                          o_out_of_range
);
    import dpsc_pkg::*;

    // flagged queries carry no count
    `DPSC_ASSERT(a_oor_zero, o_valid && o_out_of_range |-> o_ways == '0 && !o_saturated, "out of range result with nonzero ways")

    // a saturated count reads as all ones
    `DPSC_ASSERT_NEVER(a_sat_max, o_valid && o_saturated && (o_ways != '1), "saturated result below maximum")

    // one query in flight: ready drops after each input transfer
    `DPSC_ASSERT(a_one_query, i_valid && o_ready |=> !o_ready, "input ready held across a transfer")

    // a stalled result holds
    `DPSC_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_ways) && $stable(o_saturated) && $stable(o_out_of_range), "stalled result changed")

endmodule

bind distinct_prime_sum_counter_core dpsc_checker u_dpsc_checker (.*);
